// ===== hdl/tels_pkg.sv =====
package tels_pkg;

  // Character codes the parser and the put unit look for.
  localparam logic [7:0] ESC_CHAR      = 8'h1B;
  localparam logic [7:0] LBRACKET_CHAR = 8'h5B;
  localparam logic [7:0] NEWLINE_CHAR  = 8'h0A;
  localparam logic [7:0] FINAL_LO      = 8'h40;
  localparam logic [7:0] FINAL_HI      = 8'h7E;
  localparam logic [7:0] CHAR_1        = 8'h31;
  localparam logic [7:0] CHAR_2        = 8'h32;
  localparam logic [7:0] CHAR_3        = 8'h33;
  localparam logic [7:0] CHAR_A        = 8'h41;
  localparam logic [7:0] CHAR_F        = 8'h46;
  localparam logic [7:0] CHAR_G        = 8'h47;
  localparam logic [7:0] CHAR_H        = 8'h48;
  localparam logic [7:0] CHAR_J        = 8'h4A;
  localparam logic [7:0] CHAR_K        = 8'h4B;

  // Longest control sequence body that is collected.
  localparam int SEQ_MAX = 7;

  // Item action codes.
  typedef enum logic [1:0] {
    ACT_STREAM = 2'd0,
    ACT_READ   = 2'd1,
    ACT_NEW    = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // What the put unit asks of the sequencer for one byte.
  typedef struct packed {
    logic write_en;
    logic set_overflow;
  } put_ctl_t;

endpackage

// ===== hdl/tels_screen_mem.sv =====
module tels_screen_mem #(
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          wr_en,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Single port, read-first, registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

endmodule

// ===== hdl/tels_put_unit.sv =====
module tels_put_unit #(
  parameter int ROWS = 64,
  parameter int COLS = 1024,
  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int CW  = $clog2(COLS),
  localparam int RUW = $clog2(ROWS + 1)
) (
  input  logic [7:0]         put_byte,
  input  logic [RW-1:0]      row,
  input  logic [CW-1:0]      column,
  input  logic [RUW-1:0]     rows_used,
  output logic [RW-1:0]      row_next,
  output logic [CW-1:0]      column_next,
  output logic [RUW-1:0]     rows_used_next,
  output tels_pkg::put_ctl_t ctl
);
  import tels_pkg::*;

  logic [RUW-1:0] row_inc;

  assign row_inc = RUW'(row) + RUW'(1);

  // A newline moves down, growing the screen on its last row (overflow
  // if no row is left); other bytes are stored unless the row is full.
  always_comb begin
    row_next       = row;
    column_next    = column;
    rows_used_next = rows_used;
    ctl            = '0;
    if (put_byte == NEWLINE_CHAR) begin
      column_next = '0;
      if (row_inc < rows_used) begin
        row_next = RW'(row_inc);
      end else if (row_inc < RUW'(ROWS)) begin
        rows_used_next = row_inc + RUW'(1);
        row_next       = RW'(row_inc);
      end else begin
        ctl.set_overflow = 1'b1;
      end
    end else if (column < CW'(COLS - 1)) begin
      ctl.write_en = 1'b1;
      column_next  = column + CW'(1);
    end
  end

endmodule

// ===== hdl/terminal_escape_line_screen_unit.sv =====
// Line screen builder for a terminal byte stream.
// Items enter on the item channel (item_valid / item_stall) and each one
// gives exactly one result word on the result channel (result_valid /
// result_stall). An item is taken when valid is high and stall is low.
// Path from acceptance to result, each ending in the final step S_DONE:
//   plain byte, cursor move, cursor up: handled at acceptance; the next
//     byte is taken only once the previous one has left S_DONE;
//   ESC followed by another byte: ESC put at acceptance, the byte in S_PUT;
//   raw replay of a sequence of n bytes: S_REPLAY puts ESC, '[' and the n bytes;
//   read of column c in range: S_SCAN, one cell a cycle through the store port;
//   erase row: S_CLEAR over the cursor's row; clear and new screen:
//     S_CLEAR over the whole store.
// The single port of the screen store and the one shared put unit each
// handle one cell per cycle.
// Reset runs a clearing pass over the whole store with item_stall high;
// no result comes of it.
// A result waits in the output register while the receiver stalls; the
// next item is still taken and processed, and its result holds in the
// last step until the register is free.
module terminal_escape_line_screen_unit #(
  parameter int ROWS = 64,
  parameter int COLS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] action,
  input  logic [7:0] byte_value,
  input  logic       end_of_stream,
  input  logic [5:0] read_row,
  input  logic [9:0] read_column,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] cell_byte,
  output logic [6:0] row_count,
  output logic [5:0] cursor_row_out,
  output logic [9:0] cursor_column_out,
  output logic       row_overflow
);
  import tels_pkg::*;

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLS);
  localparam int RUW   = $clog2(ROWS + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PUT    = 6'b000010,
    S_REPLAY = 6'b000100,
    S_CLEAR  = 6'b001000,
    S_SCAN   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    MODE_TEXT = 3'b001,
    MODE_ESC  = 3'b010,
    MODE_CSI  = 3'b100
  } parse_mode_t;

  state_t      state;
  parse_mode_t mode;

  logic [RW-1:0]  cursor_row;
  logic [CW-1:0]  cursor_column;
  logic [RUW-1:0] rows_used;
  logic           overflow;
  logic [7:0]     seq_bytes [SEQ_MAX];
  logic [2:0]     seq_len;

  logic [7:0]    byte_q;
  logic [RW-1:0] rd_row_q;
  logic [CW-1:0] rd_col_q;
  logic [7:0]    cell_q;
  logic [3:0]    rep_idx;
  logic [AW-1:0] clr_addr;
  logic          clr_row_only;
  logic          clr_reply;
  logic [CW-1:0] scan_issue;
  logic [CW-1:0] scan_chk;
  logic          chk_valid;

  logic       accept;
  action_t    act;
  logic       is_final;
  logic [2:0] seq_len_inc;
  logic       csi_end;
  logic       m_up, m_clear, m_erase, m_f, m_g, m_h;
  logic       rd_in_range;
  logic [2:0] rep_pos;
  logic [7:0] rep_byte;
  logic       clr_last;

  logic               put_go;
  logic [7:0]         put_byte;
  logic [RW-1:0]      put_row_next;
  logic [CW-1:0]      put_column_next;
  logic [RUW-1:0]     put_rows_used_next;
  put_ctl_t           put_ctl;

  logic [AW-1:0] mem_addr;
  logic          mem_wr_en;
  logic [7:0]    mem_wr_data;
  logic [7:0]    mem_rd_data;

  assign item_stall = rst || (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign act        = action_t'(action);

  // Control sequence decode against the byte now arriving.
  assign is_final    = (byte_value >= FINAL_LO) && (byte_value <= FINAL_HI);
  assign seq_len_inc = seq_len + 3'd1;
  assign csi_end     = is_final || (seq_len_inc == 3'(SEQ_MAX));
  assign m_up    = (seq_len == 3'd1) && (seq_bytes[0] == CHAR_1) && (byte_value == CHAR_A);
  assign m_clear = (seq_len == 3'd1) && ((seq_bytes[0] == CHAR_2) || (seq_bytes[0] == CHAR_3))
                   && (byte_value == CHAR_J);
  assign m_erase = (seq_len == 3'd1) && (seq_bytes[0] == CHAR_2) && (byte_value == CHAR_K);
  assign m_f     = (seq_len == 3'd0) && (byte_value == CHAR_F);
  assign m_g     = (seq_len == 3'd0) && (byte_value == CHAR_G);
  assign m_h     = (seq_len == 3'd0) && (byte_value == CHAR_H);

  assign rd_in_range = (32'(read_row) < 32'(rows_used)) && (32'(read_column) < 32'(COLS));

  // Replay walks ESC, '[' and then the collected bytes.
  assign rep_pos  = 3'(rep_idx - 4'd2);
  assign rep_byte = (rep_idx == 4'd0) ? ESC_CHAR :
                    (rep_idx == 4'd1) ? LBRACKET_CHAR : seq_bytes[rep_pos];

  assign clr_last = (clr_addr[CW-1:0] == {CW{1'b1}})
                    && (clr_row_only || (clr_addr[AW-1:CW] == RW'(ROWS - 1)));

  // Pick the byte fed to the shared put unit in this cycle.
  always_comb begin
    put_go   = 1'b0;
    put_byte = byte_value;
    case (state)
      S_IDLE: begin
        if (accept && (act == ACT_STREAM)) begin
          if (mode == MODE_TEXT) begin
            put_go = (byte_value != ESC_CHAR) || end_of_stream;
          end else if ((mode == MODE_ESC) && (byte_value != LBRACKET_CHAR)) begin
            put_go   = 1'b1;
            put_byte = ESC_CHAR;
          end
        end
      end
      S_PUT: begin
        put_go   = 1'b1;
        put_byte = byte_q;
      end
      S_REPLAY: begin
        put_go   = 1'b1;
        put_byte = rep_byte;
      end
      default: begin
      end
    endcase
  end

  tels_put_unit #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_put (
    .put_byte       (put_byte),
    .row            (cursor_row),
    .column         (cursor_column),
    .rows_used      (rows_used),
    .row_next       (put_row_next),
    .column_next    (put_column_next),
    .rows_used_next (put_rows_used_next),
    .ctl            (put_ctl)
  );

  // Store port: put writes at the cursor, the sweep writes zeros, the scan reads.
  always_comb begin
    mem_addr    = {cursor_row, cursor_column};
    mem_wr_en   = put_go && put_ctl.write_en;
    mem_wr_data = put_byte;
    case (state)
      S_CLEAR: begin
        mem_addr    = clr_addr;
        mem_wr_en   = 1'b1;
        mem_wr_data = 8'd0;
      end
      S_SCAN: begin
        mem_addr  = {rd_row_q, scan_issue};
        mem_wr_en = 1'b0;
      end
      default: begin
      end
    endcase
  end

  tels_screen_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .addr    (mem_addr),
    .wr_en   (mem_wr_en),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      clr_row_only  <= 1'b0;
      clr_reply     <= 1'b0;
      mode          <= MODE_TEXT;
      seq_len       <= 3'd0;
      cursor_row    <= '0;
      cursor_column <= '0;
      rows_used     <= RUW'(1);
      overflow      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (put_go) begin
        cursor_row    <= put_row_next;
        cursor_column <= put_column_next;
        rows_used     <= put_rows_used_next;
        if (put_ctl.set_overflow) begin
          overflow <= 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            byte_q   <= byte_value;
            cell_q   <= 8'd0;
            rd_row_q <= RW'(read_row);
            rd_col_q <= CW'(read_column);
            state    <= S_DONE;
            case (act)
              ACT_STREAM: begin
                case (mode)
                  MODE_TEXT: begin
                    if ((byte_value == ESC_CHAR) && !end_of_stream) begin
                      mode <= MODE_ESC;
                    end
                  end
                  MODE_ESC: begin
                    if (byte_value == LBRACKET_CHAR) begin
                      seq_len <= 3'd0;
                      if (end_of_stream) begin
                        mode    <= MODE_TEXT;
                        rep_idx <= 4'd0;
                        state   <= S_REPLAY;
                      end else begin
                        mode <= MODE_CSI;
                      end
                    end else begin
                      mode  <= MODE_TEXT;
                      state <= S_PUT;
                    end
                  end
                  MODE_CSI: begin
                    seq_bytes[seq_len] <= byte_value;
                    if (csi_end) begin
                      mode    <= MODE_TEXT;
                      seq_len <= 3'd0;
                      if (m_up) begin
                        if (cursor_row != '0) begin
                          cursor_row <= cursor_row - RW'(1);
                        end
                      end else if (m_clear) begin
                        cursor_row    <= '0;
                        cursor_column <= '0;
                        rows_used     <= RUW'(1);
                        clr_addr      <= '0;
                        clr_row_only  <= 1'b0;
                        clr_reply     <= 1'b1;
                        state         <= S_CLEAR;
                      end else if (m_erase) begin
                        clr_addr     <= {cursor_row, {CW{1'b0}}};
                        clr_row_only <= 1'b1;
                        clr_reply    <= 1'b1;
                        state        <= S_CLEAR;
                      end else if (m_f) begin
                        if (cursor_row != '0) begin
                          cursor_row <= cursor_row - RW'(1);
                        end
                        cursor_column <= '0;
                      end else if (m_g) begin
                        cursor_column <= '0;
                      end else if (m_h) begin
                        cursor_row    <= '0;
                        cursor_column <= '0;
                      end else begin
                        seq_len <= seq_len_inc;
                        rep_idx <= 4'd0;
                        state   <= S_REPLAY;
                      end
                    end else if (end_of_stream) begin
                      mode    <= MODE_TEXT;
                      seq_len <= seq_len_inc;
                      rep_idx <= 4'd0;
                      state   <= S_REPLAY;
                    end else begin
                      seq_len <= seq_len_inc;
                    end
                  end
                  default: begin
                    mode <= MODE_TEXT;
                  end
                endcase
              end
              ACT_READ: begin
                if (rd_in_range) begin
                  scan_issue <= '0;
                  scan_chk   <= '0;
                  chk_valid  <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              ACT_NEW: begin
                mode          <= MODE_TEXT;
                seq_len       <= 3'd0;
                cursor_row    <= '0;
                cursor_column <= '0;
                rows_used     <= RUW'(1);
                overflow      <= 1'b0;
                clr_addr      <= '0;
                clr_row_only  <= 1'b0;
                clr_reply     <= 1'b1;
                state         <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end

        S_PUT: begin
          state <= S_DONE;
        end

        // One replayed byte per cycle; the last one is '[' plus seq_len bytes.
        S_REPLAY: begin
          if (rep_idx == ({1'b0, seq_len} + 4'd1)) begin
            seq_len <= 3'd0;
            mode    <= MODE_TEXT;
            state   <= S_DONE;
          end else begin
            rep_idx <= rep_idx + 4'd1;
          end
        end

        // Zero one cell per cycle over a row or the whole store.
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_last) begin
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end

        // Reads run one cell ahead of the zero check.
        S_SCAN: begin
          scan_issue <= scan_issue + CW'(1);
          chk_valid  <= 1'b1;
          if (chk_valid) begin
            if (mem_rd_data == 8'd0) begin
              cell_q <= 8'd0;
              state  <= S_DONE;
            end else if (scan_chk == rd_col_q) begin
              cell_q <= mem_rd_data;
              state  <= S_DONE;
            end else begin
              scan_chk <= scan_chk + CW'(1);
            end
          end
        end

        S_DONE: begin
          if (!result_valid || !result_stall) begin
            cell_byte         <= cell_q;
            row_count         <= 7'(rows_used);
            cursor_row_out    <= 6'(cursor_row);
            cursor_column_out <= 10'(cursor_column);
            row_overflow      <= overflow;
            result_valid      <= 1'b1;
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The cursor always lies on a row in use.
  a_cursor_in_rows: assert property (@(posedge clk) disable iff (rst)
    RUW'(cursor_row) < rows_used)
    else $error("cursor row beyond rows in use");

  // The cursor column never moves past the last cell of a row.
  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    cursor_column <= CW'(COLS - 1))
    else $error("cursor column past last writable cell");

  // A new result word only comes from the final step of an item.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result raised outside final step");

  // The scan never checks past the requested column.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && chk_valid |-> scan_chk <= rd_col_q)
    else $error("scan ran past requested column");

endmodule
